// ===== rtl/accel_frame_tilt_angles_top_assert.svh =====
// Assertion macros for the tilt angle block
`ifndef ACCEL_FRAME_TILT_ANGLES_TOP_ASSERT_SVH
`define ACCEL_FRAME_TILT_ANGLES_TOP_ASSERT_SVH

// Check that an implication holds on every clock edge outside reset
`define AFT_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Check that an implication holds in the cycle after its trigger
`define AFT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/aft_pkg.sv =====
// ----------------------------------------------------------------------------
// aft_pkg
// Shared types, constants and the arctangent table for the tilt angle block.
// ----------------------------------------------------------------------------
package aft_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int FilterFracDefault  = 8;
   localparam int AngleFrac          = 16;
   localparam int AngleWidth         = 28;

   localparam logic [7:0] StartByte = 8'h49;
   localparam logic [7:0] EndByte   = 8'h46;

   localparam logic [2:0] ShiftReset = 3'd1;

   // parse phases
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_END     = 2'd2
   } phase_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILTER,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQRT,
      ST_ROLL_SETUP,
      ST_ROLL_RUN,
      ST_PITCH_SETUP,
      ST_PITCH_RUN,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic filter;
      logic sq_y;
      logic sq_z;
      logic sqrt_start;
      logic roll_setup;
      logic pitch_setup;
      logic cordic_step;
      logic save_roll;
      logic save_pitch;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic sqrt_done;
      logic cordic_done;
   } sts_type;

   // arctangent in degrees, 16 fraction bits
   function automatic logic [21:0] atan_entry(input logic [4:0] idx);
      logic [21:0] v;
      case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234378;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/aft_if.sv =====
// ----------------------------------------------------------------------------
// aft_req_if / aft_rsp_if
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface aft_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface aft_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_status;
   logic signed [8:0]  roll_deg;
   logic signed [7:0]  pitch_deg;
   logic signed [15:0] raw_x;
   logic signed [15:0] raw_y;
   logic signed [15:0] raw_z;
   modport source (output valid, output frame_status, output roll_deg, output pitch_deg,
                   output raw_x, output raw_y, output raw_z, input ready);
   modport sink   (input valid, input frame_status, input roll_deg, input pitch_deg,
                   input raw_x, input raw_y, input raw_z, output ready);
endinterface

// ===== rtl/aft_ctrl.sv =====
// ----------------------------------------------------------------------------
// aft_ctrl
// Sequencer for the angle computation of one good frame.
// ----------------------------------------------------------------------------
module aft_ctrl
   import aft_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     out_free,
   input  sts_type  sts,
   output cmd_type  cmd,
   output logic     busy,
   output logic     done
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:        if (start) state_in = ST_FILTER;
         ST_FILTER:      state_in = ST_SQ_Y;
         ST_SQ_Y:        state_in = ST_SQ_Z;
         ST_SQ_Z:        state_in = ST_SQRT;
         ST_SQRT:        if (sts.sqrt_done) state_in = ST_ROLL_SETUP;
         ST_ROLL_SETUP:  state_in = ST_ROLL_RUN;
         ST_ROLL_RUN:    if (sts.cordic_done) state_in = ST_PITCH_SETUP;
         ST_PITCH_SETUP: state_in = ST_PITCH_RUN;
         ST_PITCH_RUN:   if (sts.cordic_done) state_in = ST_DONE;
         ST_DONE:        if (out_free) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         ST_IDLE:        busy = 1'b0;
         ST_FILTER:      cmd.filter = 1'b1;
         ST_SQ_Y:        cmd.sq_y = 1'b1;
         ST_SQ_Z: begin
            cmd.sq_z = 1'b1;
         end
         ST_SQRT: begin
            cmd.sqrt_start = 1'b0;
         end
         ST_ROLL_SETUP:  cmd.roll_setup = 1'b1;
         ST_ROLL_RUN: begin
            cmd.cordic_step = 1'b1;
            cmd.save_roll   = sts.cordic_done;
         end
         ST_PITCH_SETUP: cmd.pitch_setup = 1'b1;
         ST_PITCH_RUN: begin
            cmd.cordic_step = 1'b1;
            cmd.save_pitch  = sts.cordic_done;
         end
         ST_DONE:        done = 1'b1;
         default:        busy = 1'b0;
      endcase
      cmd.sqrt_start = (state_ff == ST_SQ_Z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/aft_dp.sv =====
// ----------------------------------------------------------------------------
// aft_dp
// Filters, squares, bit-serial square root and a shared CORDIC vectoring unit.
// ----------------------------------------------------------------------------
module aft_dp
   import aft_pkg::*;
#(
   parameter int CORDIC_STEPS         = CordicStepsDefault,
   parameter int FILTER_FRACTION_BITS = FilterFracDefault
)(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [2:0]         shift,
   input  logic signed [15:0] raw_x,
   input  logic signed [15:0] raw_y,
   input  logic signed [15:0] raw_z,
   output sts_type            sts,
   output logic signed [8:0]  roll_deg,
   output logic signed [7:0]  pitch_deg
);

   localparam int FW   = 16 + FILTER_FRACTION_BITS + 1;  // filter width
   localparam int SQW  = 2 * FW;                          // sum of squares
   localparam int RW   = FW + 1;                          // root width
   localparam int CW   = FW + 3;                          // cordic x/y width
   localparam int NSTP = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
   localparam int SQIT = SQW / 2;
   localparam int ItW  = $clog2(SQIT + 1);

   logic signed [FW-1:0] fx_ff, fy_ff, fz_ff;
   logic [SQW-1:0]       sq_ff, sq_in;
   logic [SQW-1:0]       rem_ff;
   logic [RW-1:0]        root_ff;
   logic [ItW-1:0]       sq_cnt_ff;
   logic                 sq_run_ff;

   // filter update, floor shift of the difference
   function automatic logic signed [FW-1:0] filt(input logic signed [FW-1:0] f,
                                                 input logic signed [15:0] s,
                                                 input logic [2:0] sh);
      logic signed [FW:0] tgt, diff;
      tgt  = FW'(s) <<< FILTER_FRACTION_BITS;
      diff = tgt - (FW+1)'(f);
      return FW'((FW+1)'(f) + (diff >>> sh));
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= '0;
         fy_ff <= '0;
         fz_ff <= '0;
      end else if (cmd.filter) begin
         fx_ff <= filt(fx_ff, raw_x, shift);
         fy_ff <= filt(fy_ff, raw_y, shift);
         fz_ff <= filt(fz_ff, raw_z, shift);
      end
   end

   // squares, one multiplier per cycle
   logic signed [FW-1:0] sq_op;
   logic signed [SQW-1:0] sq_prod;
   assign sq_op   = cmd.sq_y ? fy_ff : fz_ff;
   assign sq_prod = SQW'(sq_op) * SQW'(sq_op);
   always_comb begin
      sq_in = sq_ff;
      if (cmd.sq_y) sq_in = SQW'(sq_prod);
      else if (cmd.sq_z) sq_in = sq_ff + SQW'(sq_prod);
   end
   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   // restoring square root, one result bit per cycle
   logic [SQW-1:0] sq_shift_ff;
   logic [SQW+1:0] rem_sh_s;
   logic [SQW+1:0] trial_s;
   assign rem_sh_s = {rem_ff, sq_shift_ff[SQW-1 -: 2]};
   assign trial_s  = rem_sh_s - {(SQW+2-RW-2)'(0), root_ff, 2'b01};
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_run_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sq_run_ff <= 1'b1;
      end else if (sq_run_ff && sq_cnt_ff == ItW'(SQIT - 1)) begin
         sq_run_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rem_ff      <= '0;
         root_ff     <= '0;
         sq_cnt_ff   <= '0;
         sq_shift_ff <= sq_in;
      end else if (sq_run_ff) begin
         sq_cnt_ff   <= sq_cnt_ff + 1'b1;
         sq_shift_ff <= sq_shift_ff << 2;
         if (!trial_s[SQW+1]) begin
            rem_ff  <= SQW'(trial_s);
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= SQW'(rem_sh_s);
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end
   assign sts.sqrt_done = sq_run_ff && sq_cnt_ff == ItW'(SQIT - 1);

   // shared cordic vectoring unit
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [AngleWidth-1:0] cz_ff, ang_ff;
   logic [4:0] it_ff;
   logic       byp_ff;
   logic signed [CW-1:0] ix, iy;
   logic signed [AngleWidth-1:0] iz, ang_byp;
   logic       byp;

   always_comb begin
      ix = cmd.roll_setup ? CW'(fz_ff) : CW'($signed({1'b0, root_ff}));
      iy = cmd.roll_setup ? -CW'(fy_ff) : CW'(fx_ff);
      iz = '0;
      byp = 1'b0;
      ang_byp = '0;
      if (iy == 0) begin
         byp = 1'b1;
         ang_byp = (ix < 0) ? AngleWidth'(180 <<< AngleFrac) : '0;
      end else if (ix == 0) begin
         byp = 1'b1;
         ang_byp = (iy > 0) ? AngleWidth'(90 <<< AngleFrac)
                            : -AngleWidth'(90 <<< AngleFrac);
      end else if (ix < 0) begin
         if (iy > 0) begin
            iz = AngleWidth'(90 <<< AngleFrac);
            {ix, iy} = {iy, -ix};
         end else begin
            iz = -AngleWidth'(90 <<< AngleFrac);
            {ix, iy} = {-iy, ix};
         end
      end
   end

   logic signed [CW-1:0] dx, dy;
   logic signed [AngleWidth-1:0] at;
   assign dx = cy_ff >>> it_ff;
   assign dy = cx_ff >>> it_ff;
   assign at = AngleWidth'(atan_entry(it_ff));
   assign sts.cordic_done = cmd.cordic_step && (byp_ff || it_ff == 5'(NSTP));

   always_ff @(posedge clock) begin
      if (cmd.roll_setup || cmd.pitch_setup) begin
         cx_ff  <= ix;
         cy_ff  <= iy;
         cz_ff  <= byp ? ang_byp : iz;
         it_ff  <= '0;
         byp_ff <= byp;
      end else if (cmd.cordic_step && !sts.cordic_done) begin
         it_ff <= it_ff + 1'b1;
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + at;
         end else begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - at;
         end
      end
   end
   assign ang_ff = cz_ff;

   // truncate toward zero into whole degrees
   logic signed [AngleWidth-1:0] ang_abs;
   logic [AngleWidth-AngleFrac-1:0] deg_mag;
   logic signed [AngleWidth-AngleFrac-1:0] deg;
   assign ang_abs = ang_ff[AngleWidth-1] ? -ang_ff : ang_ff;
   assign deg_mag = ang_abs[AngleWidth-1:AngleFrac];
   assign deg     = ang_ff[AngleWidth-1] ? -$signed(deg_mag) : $signed(deg_mag);

   always_ff @(posedge clock) begin
      if (cmd.save_roll)  roll_deg  <= 9'(deg);
      if (cmd.save_pitch) pitch_deg <= 8'(deg);
   end

endmodule

// ===== rtl/accel_frame_tilt_angles_top.sv =====
// Timing: after the end byte of a good frame the serial square root and the shared
// CORDIC unit run in turn (shorter when an angle operand is zero), and the result
// word is valid the cycle after the sequencer reaches its done state. A bad end
// byte gives a result next cycle.
// Throughput: one byte per cycle except while a result waits or a frame is computed.
// Reset: synchronous, active high; parser hunts, filters clear, shift is 1.
// ----------------------------------------------------------------------------
// accel_frame_tilt_angles_top
// Frame parser, low-pass filters and roll/pitch output in whole degrees.
// ----------------------------------------------------------------------------
`include "accel_frame_tilt_angles_top_assert.svh"
module accel_frame_tilt_angles_top
   import aft_pkg::*;
#(
   parameter int CORDIC_STEPS         = CordicStepsDefault,
   parameter int FILTER_FRACTION_BITS = FilterFracDefault
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_write_data,
   aft_req_if.sink    req,
   aft_rsp_if.source  rsp
);

   logic [2:0]  shift_ff;
   phase_type   phase_ff;
   logic [2:0]  pos_ff;
   logic [7:0]  pay_ff [6];
   logic        out_valid_ff;
   logic        out_status_ff;
   logic signed [15:0] rx_ff, ry_ff, rz_ff;
   cmd_type     cmd;
   sts_type     sts;
   logic        busy, done, start;
   logic signed [8:0] roll_w;
   logic signed [7:0] pitch_w;
   logic        accept, end_byte;
   logic signed [15:0] ax, ay, az;

   // hold the smoothing shift
   always_ff @(posedge clock) begin
      if (reset) shift_ff <= ShiftReset;
      else if (csr_write_enable) shift_ff <= csr_write_data;
   end

   assign req.ready = !busy && !out_valid_ff;
   assign accept    = req.valid && req.ready;
   assign end_byte  = accept && phase_ff == PH_END;
   assign ax = {pay_ff[1], pay_ff[0]};
   assign ay = {pay_ff[3], pay_ff[2]};
   assign az = {pay_ff[5], pay_ff[4]};
   assign start = end_byte && req.rx_byte == EndByte;

   // parse each byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
      end else if (accept) begin
         case (phase_ff)
            PH_PAYLOAD: begin
               if (pos_ff == 3'd5) begin
                  pos_ff   <= '0;
                  phase_ff <= PH_END;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            PH_END: begin
               phase_ff <= PH_HUNT;
               pos_ff   <= '0;
            end
            default: begin
               phase_ff <= (req.rx_byte == StartByte) ? PH_PAYLOAD : PH_HUNT;
               pos_ff   <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_PAYLOAD) pay_ff[pos_ff] <= req.rx_byte;
      if (end_byte) begin
         rx_ff <= ax;
         ry_ff <= ay;
         rz_ff <= az;
         out_status_ff <= (req.rx_byte != EndByte);
      end
   end

   // raise the result word; good frames wait for the sequencer
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (out_valid_ff && rsp.ready) out_valid_ff <= 1'b0;
      else if (end_byte && req.rx_byte != EndByte) out_valid_ff <= 1'b1;
      else if (done) out_valid_ff <= 1'b1;
   end

   aft_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .out_free(1'b1),
      .sts(sts), .cmd(cmd), .busy(busy), .done(done)
   );

   aft_dp #(
      .CORDIC_STEPS(CORDIC_STEPS), .FILTER_FRACTION_BITS(FILTER_FRACTION_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .shift(shift_ff),
      .raw_x(rx_ff), .raw_y(ry_ff), .raw_z(rz_ff), .sts(sts),
      .roll_deg(roll_w), .pitch_deg(pitch_w)
   );

   assign rsp.valid        = out_valid_ff;
   assign rsp.frame_status = out_status_ff;
   assign rsp.roll_deg     = out_status_ff ? 9'sd0 : roll_w;
   assign rsp.pitch_deg    = out_status_ff ? 8'sd0 : pitch_w;
   assign rsp.raw_x        = rx_ff;
   assign rsp.raw_y        = ry_ff;
   assign rsp.raw_z        = rz_ff;

   `AFT_ASSERT_IMPL(a_no_accept_busy, clock, reset, busy, !req.ready, "byte taken while busy")
   `AFT_ASSERT_NEXT(a_done_raises, clock, reset, done, rsp.valid, "result lost after done")
   `AFT_ASSERT_IMPL(a_angles_range, clock, reset, rsp.valid && !rsp.frame_status,
      rsp.pitch_deg <= 8'sd90 && rsp.pitch_deg >= -8'sd90, "pitch out of range")

endmodule
